/* src/rsba_pkg.sv */
package rsba_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int AMT_W = 25;
    localparam int TAG_W = 10;
    localparam int CNT_W = 8;
    localparam int PRICE_W = 16;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [PRICE_W-1:0] ADULT_PRICE_RST = 16'd40000;
    localparam logic [PRICE_W-1:0] CHILD_PRICE_RST = 16'd20000;

    localparam logic [CFG_IDX_W-1:0] CFG_ADULT_PRICE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHILD_PRICE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SORT_MODE   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_EXCHANGE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUBBLE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INSERTION = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ARRIVAL   = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MUL_A,
        ST_MUL_C,
        ST_WRITE,
        ST_SORT_INIT,
        ST_RD,
        ST_RD_WAIT,
        ST_CMP,
        ST_WR_B,
        ST_INS_MOVE,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT
    } t_state;

endpackage

/* src/record_sort_by_amount.sv */
// Record sorter: each input word carries an adult and a child ticket count and a tag.
// The amount (adult_count * adult_price + child_count * child_price) is formed with one
// shared 16x8 multiplier, adult product first and child product second, and stored with
// the tag; a word steps through the states load, adult multiply, child multiply and write.
// On the word with final_record set, the stored records are sorted by ascending amount in
// place, through one memory with one compare unit, with the algorithm picked by sort_mode
// (0 exchange, 1 bubble, 2 insertion, 3 leaves arrival order), then emitted in order with
// tlast on the last one. A compare reads its two operands, compares them and writes back;
// each record is emitted after a memory read and a read wait. Records past MAX_RECORDS
// are dropped. The input is not ready while a set is sorted or emitted.
module record_sort_by_amount
    import rsba_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // adult_count[7:0], child_count[15:8], record_tag[25:16], zero fill [31:26]
    input  logic [31:0]          s_axis_tdata,
    input  logic                 s_axis_tlast,   // final_record
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_tag[9:0], amount[34:10], zero fill [39:35]
    output logic [39:0]          m_axis_tdata,
    output logic                 m_axis_tlast,   // end_of_run
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PRICE_W-1:0]   i_cfg_data
);

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int NW = $clog2(MAX_RECORDS + 1);
    localparam int EW = AMT_W + TAG_W;
    localparam logic [NW-1:0] N_MAX = NW'(MAX_RECORDS);

    logic [PRICE_W-1:0] r_adult_price, r_child_price;
    logic [MODE_W-1:0]  r_mode;

    t_state r_state, n_state;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_i, n_i, r_j, n_j;
    logic          r_fin, n_fin;
    logic [CNT_W-1:0] r_child, n_child;
    logic [CNT_W-1:0] r_adult, n_adult;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [AMT_W-1:0] r_acc, n_acc;
    logic [AMT_W-1:0] r_prod;
    logic [EW-1:0] r_a, n_a, r_b, n_b;
    logic          r_ovalid, n_ovalid;
    logic          r_olast, n_olast;
    logic [EW-1:0] r_odata, n_odata;

    // One shared multiplier; operands picked by state.
    logic [PRICE_W-1:0] mul_p;
    logic [CNT_W-1:0]   mul_c;
    assign mul_p = (r_state == ST_MUL_A) ? r_adult_price : r_child_price;
    assign mul_c = (r_state == ST_MUL_A) ? r_adult : r_child;

    always_ff @(posedge i_clk) begin
        r_prod <= AMT_W'(mul_p * mul_c);
    end

    // Record store: amount in the upper bits, tag in the lower.
    logic [EW-1:0] mem [MAX_RECORDS];
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd, r_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adult_price <= ADULT_PRICE_RST;
            r_child_price <= CHILD_PRICE_RST;
            r_mode        <= MODE_EXCHANGE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ADULT_PRICE: r_adult_price <= i_cfg_data;
                CFG_CHILD_PRICE: r_child_price <= i_cfg_data;
                CFG_SORT_MODE:   r_mode        <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_i     <= n_i;
        r_j     <= n_j;
        r_fin   <= n_fin;
        r_adult <= n_adult;
        r_child <= n_child;
        r_tag   <= n_tag;
        r_acc   <= n_acc;
        r_a     <= n_a;
        r_b     <= n_b;
        r_olast <= n_olast;
        r_odata <= n_odata;
    end

    logic [AMT_W-1:0] amt_a, amt_b;
    assign amt_a = r_a[EW-1:TAG_W];
    assign amt_b = r_rd[EW-1:TAG_W];

    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {5'd0, r_odata[EW-1:TAG_W], r_odata[TAG_W-1:0]};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_j      = r_j;
        n_fin    = r_fin;
        n_adult  = r_adult;
        n_child  = r_child;
        n_tag    = r_tag;
        n_acc    = r_acc;
        n_a      = r_a;
        n_b      = r_b;
        n_ovalid = r_ovalid;
        n_olast  = r_olast;
        n_odata  = r_odata;
        mem_we   = 1'b0;
        mem_wa   = r_j[AW-1:0];
        mem_wd   = r_a;
        mem_ra   = r_j[AW-1:0];

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (s_axis_tvalid) begin
                    n_adult = s_axis_tdata[7:0];
                    n_child = s_axis_tdata[15:8];
                    n_tag   = s_axis_tdata[25:16];
                    n_fin   = s_axis_tlast;
                    n_state = ST_MUL_A;
                end
            end
            ST_MUL_A: n_state = ST_MUL_C;
            ST_MUL_C: begin
                n_acc   = r_prod;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (r_cnt < N_MAX) begin
                    mem_we = 1'b1;
                    mem_wa = r_cnt[AW-1:0];
                    mem_wd = {AMT_W'(r_acc + r_prod), r_tag};
                    n_cnt  = r_cnt + 1'b1;
                end
                n_state = r_fin ? ST_SORT_INIT : ST_LOAD;
            end
            ST_SORT_INIT: begin
                // Exchange: i=0,j=1. Bubble: i=0,j=0. Insertion: i=1.
                n_i = (r_mode == MODE_INSERTION) ? NW'(1) : '0;
                n_j = (r_mode == MODE_EXCHANGE) ? NW'(1) : '0;
                if (r_cnt < NW'(2) || r_mode == MODE_ARRIVAL) begin
                    n_i = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                // Exchange reads a[i] then a[j]; bubble a[j] then a[j+1];
                // insertion loads the key a[i], then scans a[pos-1] with j = pos.
                case (r_mode)
                    MODE_EXCHANGE: mem_ra = r_i[AW-1:0];
                    MODE_BUBBLE:   mem_ra = r_j[AW-1:0];
                    default:       mem_ra = r_i[AW-1:0];
                endcase
                n_state = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                n_a = r_rd;
                case (r_mode)
                    MODE_EXCHANGE: mem_ra = r_j[AW-1:0];
                    MODE_BUBBLE:   mem_ra = AW'(r_j + 1'b1);
                    default:       mem_ra = AW'(r_i - 1'b1);
                endcase
                if (r_mode == MODE_INSERTION) begin
                    n_j = r_i;  // j holds pos
                end
                n_state = ST_CMP;
            end
            ST_CMP: begin
                // r_a is a[i], a[j] or the key; r_rd is the other operand.
                n_state = ST_RD;
                if (r_mode == MODE_INSERTION) begin
                    if (amt_b > amt_a) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_j[AW-1:0];
                        mem_wd  = r_rd;
                        n_j     = r_j - 1'b1;
                        n_state = ST_INS_MOVE;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = r_j[AW-1:0];
                        mem_wd = r_a;
                        n_i    = r_i + 1'b1;
                        if (r_i + 1'b1 >= r_cnt) begin
                            n_i = '0;
                            n_state = ST_EMIT_RD;
                        end
                    end
                end else begin
                    if (amt_a > amt_b) begin
                        mem_we  = 1'b1;
                        mem_wa  = (r_mode == MODE_EXCHANGE) ? r_i[AW-1:0] : r_j[AW-1:0];
                        mem_wd  = r_rd;
                        n_b     = r_a;
                        n_state = ST_WR_B;
                    end else begin
                        n_state = ST_WR_B;
                        n_b     = r_rd;
                    end
                end
            end
            ST_WR_B: begin
                // Second half of a swap (rewrites the same value when none).
                mem_we = 1'b1;
                mem_wa = (r_mode == MODE_EXCHANGE) ? r_j[AW-1:0] : AW'(r_j + 1'b1);
                mem_wd = r_b;
                n_state = ST_RD;
                if (r_mode == MODE_EXCHANGE) begin
                    if (r_j + 1'b1 < r_cnt) begin
                        n_j = r_j + 1'b1;
                    end else if (r_i + NW'(2) < r_cnt) begin
                        n_i = r_i + 1'b1;
                        n_j = r_i + NW'(2);
                    end else begin
                        n_i = '0;
                        n_state = ST_EMIT_RD;
                    end
                end else begin
                    if (r_j + NW'(2) < r_cnt - r_i) begin
                        n_j = r_j + 1'b1;
                    end else if (r_i + NW'(2) < r_cnt) begin
                        n_i = r_i + 1'b1;
                        n_j = '0;
                    end else begin
                        n_i = '0;
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_INS_MOVE: begin
                // j is the new pos; key stays in r_a.
                mem_ra = AW'(r_j - 1'b1);
                if (r_j == '0) begin
                    mem_we = 1'b1;
                    mem_wa = '0;
                    mem_wd = r_a;
                    n_i    = r_i + 1'b1;
                    n_state = ST_RD;
                    if (r_i + 1'b1 >= r_cnt) begin
                        n_i = '0;
                        n_state = ST_EMIT_RD;
                    end
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_EMIT_RD: begin
                mem_ra  = r_i[AW-1:0];
                n_state = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                // Keep the read address on the entry being emitted.
                mem_ra  = r_i[AW-1:0];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                mem_ra = r_i[AW-1:0];
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_rd;
                    n_olast  = (r_i + 1'b1 == r_cnt);
                    n_i      = r_i + 1'b1;
                    if (r_i + 1'b1 == r_cnt) begin
                        n_cnt   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    ap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= N_MAX) else $error("record count beyond capacity");
    ap_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT || r_state == ST_CMP) |-> !s_axis_tready)
        else $error("ready while sorting");
    ap_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && n_state == ST_LOAD) |=> r_cnt == '0)
        else $error("count not cleared after run");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

/* dv/record_sort_by_amount_tb.sv */
module record_sort_by_amount_tb;
    import rsba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   DEPTH        = MAX_RECORDS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE     = 2'd3;
    localparam int                   SETTLE       = 30;
    localparam longint               CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [AMT_W-1:0] amount;
        logic             last;
    } t_sorted_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [PRICE_W-1:0]   i_cfg_data = '0;

    record_sort_by_amount u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: prices, mode and the record store as the block should hold them.
    logic [PRICE_W-1:0] adult_price_q;
    logic [PRICE_W-1:0] child_price_q;
    logic [MODE_W-1:0]  sort_mode_q;
    logic [AMT_W-1:0]   amount_mem [DEPTH];
    logic [TAG_W-1:0]   tag_mem [DEPTH];
    int                 stored_count;
    t_sorted_word       sorted_queue [$];

    int     error_count;
    int     items_sent;
    int     next_gap;
    bit     calm;
    int     ready_stall;
    longint cycle_count;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void swap_records(input int x, input int y);
        logic [AMT_W-1:0] a;
        logic [TAG_W-1:0] t;
        a = amount_mem[x];
        t = tag_mem[x];
        amount_mem[x] = amount_mem[y];
        tag_mem[x] = tag_mem[y];
        amount_mem[y] = a;
        tag_mem[y] = t;
    endfunction

    function automatic void sort_records(input int n);
        logic [AMT_W-1:0] ka;
        logic [TAG_W-1:0] kt;
        int               pos;
        case (sort_mode_q)
            MODE_EXCHANGE: begin
                for (int i = 0; i + 1 < n; i++)
                    for (int j = i + 1; j < n; j++)
                        if (amount_mem[i] > amount_mem[j]) swap_records(i, j);
            end
            MODE_BUBBLE: begin
                for (int i = 0; i + 1 < n; i++)
                    for (int j = 0; j + 1 < n - i; j++)
                        if (amount_mem[j] > amount_mem[j+1]) swap_records(j, j + 1);
            end
            MODE_INSERTION: begin
                for (int i = 1; i < n; i++) begin
                    ka = amount_mem[i];
                    kt = tag_mem[i];
                    pos = i;
                    while (pos > 0 && amount_mem[pos-1] > ka) begin
                        amount_mem[pos] = amount_mem[pos-1];
                        tag_mem[pos] = tag_mem[pos-1];
                        pos--;
                    end
                    amount_mem[pos] = ka;
                    tag_mem[pos] = kt;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void accept_record(input logic [7:0] adult, input logic [7:0] child,
                                          input logic [TAG_W-1:0] tag, input logic fin);
        logic [31:0]  amt;
        t_sorted_word w;
        if (stored_count < DEPTH) begin
            amt = adult * adult_price_q + child * child_price_q;
            amount_mem[stored_count] = amt[AMT_W-1:0];
            tag_mem[stored_count] = tag;
            stored_count++;
        end
        if (fin) begin
            sort_records(stored_count);
            for (int k = 0; k < stored_count; k++) begin
                w.tag = tag_mem[k];
                w.amount = amount_mem[k];
                w.last = (k + 1 == stored_count);
                sorted_queue.push_back(w);
            end
            stored_count = 0;
        end
    endfunction

    // Sends one word; with more set and a zero gap drawn, valid stays high for the next one.
    task automatic send_record(input logic [7:0] adult, input logic [7:0] child,
                               input logic [TAG_W-1:0] tag, input logic fin, input bit more);
        repeat (next_gap) @(posedge i_clk);
        s_axis_tdata <= {6'd0, tag, child, adult};
        s_axis_tlast <= fin;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        accept_record(adult, child, tag, fin);
        items_sent++;
        next_gap = calm ? 0 : $urandom_range(0, 6);
        if (!more || next_gap != 0) s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain;
        @(posedge i_clk);
        while (sorted_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        next_gap = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PRICE_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ADULT_PRICE: adult_price_q = val;
            CFG_CHILD_PRICE: child_price_q = val;
            CFG_SORT_MODE:   sort_mode_q = val[MODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_random_set(input int n, input int count_max);
        for (int k = 0; k < n; k++)
            send_record(8'($urandom_range(0, count_max)), 8'($urandom_range(0, count_max)),
                        TAG_W'($urandom_range(0, 1023)), k == n - 1, k != n - 1);
    endtask

    task automatic test_reset_prices;
        send_record(8'd0, 8'd0, 10'd0, 1'b0, 1'b1);
        send_record(8'd255, 8'd255, 10'd1023, 1'b0, 1'b1);
        send_record(8'd255, 8'd0, 10'h155, 1'b0, 1'b1);
        send_record(8'd0, 8'd255, 10'h2AA, 1'b0, 1'b1);
        send_record(8'd1, 8'd2, 10'd7, 1'b1, 1'b0);
        drain();
        // A set of one record.
        send_record(8'd3, 8'd4, 10'd512, 1'b1, 1'b0);
        drain();
    endtask

    // Unit prices give many equal amounts, so the tie order of each algorithm shows.
    task automatic test_modes;
        logic [MODE_W-1:0] modes [4] = '{MODE_EXCHANGE, MODE_BUBBLE, MODE_INSERTION,
                                         MODE_ARRIVAL};
        write_reg(CFG_ADULT_PRICE, 16'd1);
        write_reg(CFG_CHILD_PRICE, 16'd1);
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_SORT_MODE, {14'd0, modes[m]});
            send_record(8'd2, 8'd1, 10'd10, 1'b0, 1'b1);
            send_record(8'd1, 8'd0, 10'd11, 1'b0, 1'b1);
            send_record(8'd0, 8'd3, 10'd12, 1'b0, 1'b1);
            send_record(8'd1, 8'd0, 10'd13, 1'b0, 1'b1);
            send_record(8'd0, 8'd1, 10'd14, 1'b1, 1'b0);
            drain();
        end
        // Index past the register list must leave the mode alone; upper bits are masked.
        write_reg(CFG_NONE, 16'hFFFF);
        write_reg(CFG_SORT_MODE, 16'hFFFE);
        send_random_set(4, 3);
        drain();
    endtask

    // Store full: more records than fit, extreme prices; the overflow is dropped.
    task automatic test_overflow;
        write_reg(CFG_ADULT_PRICE, 16'hFFFF);
        write_reg(CFG_CHILD_PRICE, 16'hFFFF);
        write_reg(CFG_SORT_MODE, {14'd0, MODE_INSERTION});
        send_random_set(DEPTH + 4, 255);
        drain();
        write_reg(CFG_ADULT_PRICE, 16'd0);
        write_reg(CFG_CHILD_PRICE, 16'd0);
        write_reg(CFG_SORT_MODE, {14'd0, MODE_BUBBLE});
        send_random_set(DEPTH, 255);
        drain();
    endtask

    task automatic test_random;
        int n;
        int count_max;
        while (items_sent < 370) begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0: write_reg(CFG_ADULT_PRICE, 16'hFFFF);
                1: write_reg(CFG_ADULT_PRICE, PRICE_W'($urandom_range(0, 3)));
                default: write_reg(CFG_ADULT_PRICE, PRICE_W'($urandom_range(0, 65535)));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_CHILD_PRICE, 16'd0);
                1: write_reg(CFG_CHILD_PRICE, PRICE_W'($urandom_range(0, 3)));
                default: write_reg(CFG_CHILD_PRICE, PRICE_W'($urandom_range(0, 65535)));
            endcase
            write_reg(CFG_SORT_MODE, PRICE_W'($urandom_range(0, 65535)));
            for (int s = $urandom_range(1, 3); s > 0; s--) begin
                n = $urandom_range(1, 12);
                count_max = ($urandom_range(0, 1) != 0) ? 3 : 255;
                for (int k = 0; k < n; k++)
                    send_record(8'($urandom_range(0, count_max)),
                                8'($urandom_range(0, count_max)),
                                TAG_W'($urandom_range(0, 1023)), k == n - 1, 1'b1);
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_stall = $urandom_range(0, 6);
        end else if (m_axis_tready && m_axis_tvalid) begin
            ready_stall = calm ? 0 : $urandom_range(0, 6);
            m_axis_tready <= (ready_stall == 0);
        end else if (!m_axis_tready) begin
            if (ready_stall > 0) ready_stall--;
            if (ready_stall == 0) m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sorted_word w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sorted_queue.size() == 0) begin
                report_mismatch("unexpected word, tag", m_axis_tdata[9:0], -1);
            end else begin
                w = sorted_queue.pop_front();
                if (m_axis_tdata[9:0] !== w.tag)
                    report_mismatch("out_tag", m_axis_tdata[9:0], w.tag);
                if (m_axis_tdata[34:10] !== w.amount)
                    report_mismatch("amount", m_axis_tdata[34:10], w.amount);
                if (m_axis_tlast !== w.last)
                    report_mismatch("end_of_run", m_axis_tlast, w.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("record_sort_by_amount_tb NOT OK");
            $finish;
        end
    end

    initial begin
        adult_price_q = ADULT_PRICE_RST;
        child_price_q = CHILD_PRICE_RST;
        sort_mode_q = MODE_EXCHANGE;
        stored_count = 0;
        error_count = 0;
        items_sent = 0;
        next_gap = 0;
        calm = 1'b0;
        cycle_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_prices();
        test_modes();
        test_overflow();
        test_random();
        drain();
        if (error_count == 0) begin
            $display("record_sort_by_amount_tb OK");
        end else begin
            $display("record_sort_by_amount_tb NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
src/rsba_pkg.sv
src/record_sort_by_amount.sv
dv/record_sort_by_amount_tb.sv
